/* rtl/core/wsp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsp_pkg: shared types, constants and datapath functions
// Fixed-point formats, register codes, beat payloads and the per-lane
// divider step used by the world-to-screen projection pipeline.
// ----------------------------------------------------------------------------
package wsp_pkg;

  // Number formats
  localparam int FRAC_BITS = 16;               // fraction bits of coordinates
  localparam int COEF_FRAC = 16;               // fraction bits of coefficients
  localparam int COEF_W    = 20;               // signed Q4.16 coefficient
  localparam int PT_W      = 32;               // coordinate and result word
  localparam int PROD_W    = PT_W + COEF_W;    // one coordinate times coefficient
  localparam int SUM_W     = PROD_W + 2;       // sum of three products
  localparam int SH_W      = SUM_W - COEF_FRAC;
  localparam int TADD_W    = SH_W + 1;         // shifted sum plus translation
  localparam int SIZE_W    = 16;               // screen width or height
  localparam int NUM_W     = PT_W + SIZE_W;    // |t| * size
  localparam int EXT_W     = NUM_W + FRAC_BITS;
  localparam int QUO_W     = 32;               // quotient bits worked out
  localparam int HI_W      = EXT_W - QUO_W;
  localparam int DM_W      = PT_W;             // |depth|
  localparam int DIV_N     = QUO_W + 1;        // divider register stages

  // Configuration port
  localparam int CFG_W     = 64;
  localparam int REG_IDX_W = 3;
  localparam int WREG_W    = 3 * COEF_W;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_WEIGHTS_X    = 3'd0,
    REG_WEIGHTS_Y    = 3'd1,
    REG_WEIGHTS_Z    = 3'd2,
    REG_OFFSET_XY    = 3'd3,
    REG_OFFSET_DEPTH = 3'd4,
    REG_SCREEN_SIZE  = 3'd5
  } reg_idx_t;

  localparam logic [WREG_W-1:0] WEIGHTS_X_RST = WREG_W'(64'd65536);
  localparam logic [WREG_W-1:0] WEIGHTS_Y_RST = WREG_W'(64'd68719476736);
  localparam logic [WREG_W-1:0] WEIGHTS_Z_RST = WREG_W'(64'd72057594037927936);
  localparam logic [CFG_W-1:0]  OFFSET_XY_RST = '0;
  localparam logic [PT_W-1:0]   OFFSET_D_RST  = '0;
  localparam logic [PT_W-1:0]   SCREEN_RST    = PT_W'(64'd50332416);

  localparam logic [PT_W-1:0] WORD_MAX = {1'b0, {(PT_W-1){1'b1}}};
  localparam logic [PT_W-1:0] WORD_MIN = {1'b1, {(PT_W-1){1'b0}}};
  localparam logic signed [PT_W-1:0] FX_ONE = PT_W'(64'd1 << FRAC_BITS);

  // Beat payloads
  typedef struct packed {
    logic signed [PT_W-1:0] world_x;
    logic signed [PT_W-1:0] world_y;
    logic signed [PT_W-1:0] world_z;
  } point_t;

  typedef struct packed {
    logic signed [PT_W-1:0] screen_x;
    logic signed [PT_W-1:0] screen_y;
    logic signed [PT_W-1:0] depth;
    logic                   behind_camera;
    logic                   zero_depth;
  } proj_t;

  // One division lane: partial remainder, quotient so far, dividend bits left
  typedef struct packed {
    logic [DM_W-1:0]  rem;
    logic [QUO_W-1:0] quo;
    logic [QUO_W-1:0] low;
    logic             ovf;
    logic             neg;
    logic             num_zero;
    logic             t_neg;
  } lane_t;

  // Values shared by both lanes
  typedef struct packed {
    logic [DM_W-1:0]        dm;
    logic signed [PT_W-1:0] depth;
    logic                   behind;
    logic                   zero;
  } side_t;

  typedef struct packed {
    side_t side;
    lane_t lx;
    lane_t ly;
  } div_t;

  // Signed coordinate times signed coefficient, full width
  function automatic logic signed [PROD_W-1:0] mul_coef(
    input logic signed [PT_W-1:0]   a,
    input logic signed [COEF_W-1:0] b
  );
    return a * b;
  endfunction

  // Clamp to the signed result word
  function automatic logic signed [PT_W-1:0] sat_word(input logic [TADD_W-1:0] v);
    logic fits;
    fits = (&v[TADD_W-1:PT_W-1]) || !(|v[TADD_W-1:PT_W-1]);
    if (fits) begin
      return v[PT_W-1:0];
    end
    return v[TADD_W-1] ? WORD_MIN : WORD_MAX;
  endfunction

  // Magnitude of a signed word; the most negative value maps to 2^(PT_W-1)
  function automatic logic [PT_W-1:0] mag_word(input logic [PT_W-1:0] v);
    return v[PT_W-1] ? (~v + PT_W'(1)) : v;
  endfunction

  function automatic logic [NUM_W-1:0] mul_size(
    input logic [PT_W-1:0]   m,
    input logic [SIZE_W-1:0] s
  );
    return m * s;
  endfunction

  // Load a lane: dividend is num * 2^FRAC_BITS, overflow when quotient >= 2^QUO_W
  function automatic lane_t lane_init(
    input logic [NUM_W-1:0] num,
    input logic             t_neg,
    input logic             neg,
    input logic [DM_W-1:0]  dm
  );
    logic [EXT_W-1:0] ext;
    logic [HI_W-1:0]  hi;
    lane_t            l;
    ext        = {num, {FRAC_BITS{1'b0}}};
    hi         = ext[EXT_W-1:QUO_W];
    l.ovf      = (EXT_W'(hi) >= EXT_W'(dm));
    l.rem      = DM_W'(hi);
    l.low      = ext[QUO_W-1:0];
    l.quo      = '0;
    l.neg      = neg;
    l.t_neg    = t_neg;
    l.num_zero = (num == '0);
    return l;
  endfunction

  // One restoring step: bring in the next dividend bit, subtract when it fits
  function automatic lane_t lane_step(input lane_t l, input logic [DM_W-1:0] dm);
    logic [DM_W:0] trial;
    logic          qbit;
    lane_t         n;
    n     = l;
    trial = {l.rem, l.low[QUO_W-1]};
    qbit  = 1'b0;
    if (trial >= {1'b0, dm}) begin
      trial = trial - {1'b0, dm};
      qbit  = 1'b1;
    end
    n.rem = trial[DM_W-1:0];
    n.quo = {l.quo[QUO_W-2:0], qbit};
    n.low = {l.low[QUO_W-2:0], 1'b0};
    return n;
  endfunction

  // Apply special cases, sign and saturation to a finished quotient
  function automatic logic signed [PT_W-1:0] lane_finish(input lane_t l, input logic zero);
    logic big_neg;
    big_neg = l.quo[QUO_W-1] && (|l.quo[QUO_W-2:0]);
    if (l.num_zero) begin
      return '0;
    end
    if (zero) begin
      return l.t_neg ? WORD_MIN : WORD_MAX;
    end
    if (l.neg) begin
      if (l.ovf || big_neg) begin
        return WORD_MIN;
      end
      return ~l.quo[PT_W-1:0] + PT_W'(1);
    end
    if (l.ovf || l.quo[QUO_W-1]) begin
      return WORD_MAX;
    end
    return l.quo[PT_W-1:0];
  endfunction

endpackage

/* rtl/core/wsp_stream_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsp_stream_if: valid/ready stream channel
// Carries one payload beat per accepted handshake, valid and ready both high.
// ----------------------------------------------------------------------------
interface wsp_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

/* rtl/core/world_to_screen_projection.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// world_to_screen_projection: fixed-point perspective projection pipeline
// Transforms world points by a 3x3 matrix and translation, then divides
// x and y by depth and scales them by the screen size.
// ----------------------------------------------------------------------------
// Usage:
//   point  : sink channel, one world point (Q16.16 x, y, z) per beat.
//   proj   : source channel, one result per point: screen x and y, depth,
//            behind-camera and zero-depth flags, in input order.
//   cfg_*  : write port for the matrix, translations and screen size; write
//            only while no point is in flight.
// Throughput: one point per cycle, sustained while proj is ready.
// Stages: 38 register stages: products, sums, shift and translate, magnitudes
//   and size product, divider load, 32 restoring divider stages (one quotient
//   bit each), output register; the first stage loads at the accepting edge.
// Stall: each stage holds while the one after it is full and blocked; empty
//   stages keep filling, so points are still taken while a result waits.
// Reset: synchronous; empties the pipeline and returns the registers to an
//   identity matrix, zero translation and a 768 x 768 screen.
// ----------------------------------------------------------------------------
module world_to_screen_projection (
  input  logic                           clk,
  input  logic                           rst,
  wsp_stream_if.sink                     point,
  wsp_stream_if.source                   proj,
  input  logic                           cfg_we,
  input  logic [wsp_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [wsp_pkg::CFG_W-1:0]      cfg_data
);

  import wsp_pkg::*;

  // Configuration registers
  logic [WREG_W-1:0] w_reg [3];
  logic [CFG_W-1:0]  off_xy;
  logic [PT_W-1:0]   off_d;
  logic [PT_W-1:0]   size_reg;

  // Stage registers
  logic                     p_v;
  logic signed [PROD_W-1:0] p_prod [3][3];   // [output][input]
  logic                     s_v;
  logic signed [SUM_W-1:0]  s_sum [3];
  logic                     t_v;
  logic signed [PT_W-1:0]   t_tr [3];
  logic                     m_v;
  logic [NUM_W-1:0]         m_numx;
  logic [NUM_W-1:0]         m_numy;
  logic                     m_tnx;
  logic                     m_tny;
  logic                     m_negx;
  logic                     m_negy;
  side_t                    m_side;
  logic                     dv_v [DIV_N];
  div_t                     dv   [DIV_N];
  logic                     o_v;
  proj_t                    o_data;

  // Stage enables: a stage takes a beat when it is empty or its beat moves on
  logic en_p;
  logic en_s;
  logic en_t;
  logic en_m;
  logic en_d [DIV_N+1];
  logic en_o;

  logic signed [COEF_W-1:0] coef [3][3];     // [input][output]
  logic signed [PT_W-1:0]   pt_in [3];
  logic signed [PT_W-1:0]   off [3];
  logic [SIZE_W-1:0]        scr_w;
  logic [SIZE_W-1:0]        scr_h;

  // Write configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      w_reg[0] <= WEIGHTS_X_RST;
      w_reg[1] <= WEIGHTS_Y_RST;
      w_reg[2] <= WEIGHTS_Z_RST;
      off_xy   <= OFFSET_XY_RST;
      off_d    <= OFFSET_D_RST;
      size_reg <= SCREEN_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_WEIGHTS_X:    w_reg[0] <= cfg_data[WREG_W-1:0];
        REG_WEIGHTS_Y:    w_reg[1] <= cfg_data[WREG_W-1:0];
        REG_WEIGHTS_Z:    w_reg[2] <= cfg_data[WREG_W-1:0];
        REG_OFFSET_XY:    off_xy   <= cfg_data;
        REG_OFFSET_DEPTH: off_d    <= cfg_data[PT_W-1:0];
        REG_SCREEN_SIZE:  size_reg <= cfg_data[PT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Unpack coefficients, translations and screen size
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        coef[i][k] = w_reg[i][k*COEF_W +: COEF_W];
      end
    end
    off[0] = off_xy[CFG_W-1:PT_W];
    off[1] = off_xy[PT_W-1:0];
    off[2] = off_d;
    scr_w  = size_reg[PT_W-1:SIZE_W];
    scr_h  = size_reg[SIZE_W-1:0];
    pt_in[0] = point.data.world_x;
    pt_in[1] = point.data.world_y;
    pt_in[2] = point.data.world_z;
  end

  // Ready chain, back from the output register
  assign en_o         = !o_v || proj.ready;
  assign en_d[DIV_N]  = en_o;
  assign en_m         = !m_v || en_d[0];
  assign en_t         = !t_v || en_m;
  assign en_s         = !s_v || en_t;
  assign en_p         = !p_v || en_s;
  assign point.ready  = en_p;

  for (genvar g = 0; g < DIV_N; g++) begin : g_en
    assign en_d[g] = !dv_v[g] || en_d[g+1];
  end

  // Valid bits of the front stages
  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
      s_v <= 1'b0;
      t_v <= 1'b0;
      m_v <= 1'b0;
    end else begin
      if (en_p) p_v <= point.valid;
      if (en_s) s_v <= p_v;
      if (en_t) t_v <= s_v;
      if (en_m) m_v <= t_v;
    end
  end

  // Multiply each coordinate by its three coefficients
  always_ff @(posedge clk) begin
    if (en_p) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          p_prod[k][i] <= mul_coef(pt_in[i], coef[i][k]);
        end
      end
    end
  end

  // Sum the products of each output
  always_ff @(posedge clk) begin
    if (en_s) begin
      for (int k = 0; k < 3; k++) begin
        s_sum[k] <= {{2{p_prod[k][0][PROD_W-1]}}, p_prod[k][0]}
                  + {{2{p_prod[k][1][PROD_W-1]}}, p_prod[k][1]}
                  + {{2{p_prod[k][2][PROD_W-1]}}, p_prod[k][2]};
      end
    end
  end

  // Drop coefficient fraction (floor), translate and saturate
  always_ff @(posedge clk) begin
    if (en_t) begin
      for (int k = 0; k < 3; k++) begin
        t_tr[k] <= sat_word({s_sum[k][SUM_W-1], s_sum[k][SUM_W-1:COEF_FRAC]}
                          + {{(TADD_W-PT_W){off[k][PT_W-1]}}, off[k]});
      end
    end
  end

  // Magnitudes, size products, signs and depth flags
  always_ff @(posedge clk) begin
    if (en_m) begin
      m_numx        <= mul_size(mag_word(t_tr[0]), scr_w);
      m_numy        <= mul_size(mag_word(t_tr[1]), scr_h);
      m_tnx         <= t_tr[0][PT_W-1];
      m_tny         <= t_tr[1][PT_W-1];
      m_negx        <= t_tr[0][PT_W-1] ^ t_tr[2][PT_W-1];
      m_negy        <= t_tr[1][PT_W-1] ^ t_tr[2][PT_W-1];
      m_side.dm     <= mag_word(t_tr[2]);
      m_side.depth  <= t_tr[2];
      m_side.behind <= (t_tr[2] < FX_ONE);
      m_side.zero   <= (t_tr[2] == '0);
    end
  end

  // Load the divider lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en_d[0]) begin
      dv_v[0] <= m_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en_d[0]) begin
      dv[0].side <= m_side;
      dv[0].lx   <= lane_init(m_numx, m_tnx, m_negx, m_side.dm);
      dv[0].ly   <= lane_init(m_numy, m_tny, m_negy, m_side.dm);
    end
  end

  // Restoring divider, one quotient bit per stage in both lanes
  for (genvar g = 1; g < DIV_N; g++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[g] <= 1'b0;
      end else if (en_d[g]) begin
        dv_v[g] <= dv_v[g-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en_d[g]) begin
        dv[g].side <= dv[g-1].side;
        dv[g].lx   <= lane_step(dv[g-1].lx, dv[g-1].side.dm);
        dv[g].ly   <= lane_step(dv[g-1].ly, dv[g-1].side.dm);
      end
    end
  end

  // Sign, saturate and hold the result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      o_v <= 1'b0;
    end else if (en_o) begin
      o_v <= dv_v[DIV_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      o_data.screen_x      <= lane_finish(dv[DIV_N-1].lx, dv[DIV_N-1].side.zero);
      o_data.screen_y      <= lane_finish(dv[DIV_N-1].ly, dv[DIV_N-1].side.zero);
      o_data.depth         <= dv[DIV_N-1].side.depth;
      o_data.behind_camera <= dv[DIV_N-1].side.behind;
      o_data.zero_depth    <= dv[DIV_N-1].side.zero;
    end
  end

  assign proj.valid = o_v;
  assign proj.data  = o_data;

endmodule
